// ----- rtl/prqs_pkg.sv -----
// Shared widths, codes and parameter defaults for the priority ready-queue scheduler.
`default_nettype none

package prqs_pkg;

   // Field widths of the request and response channels
   localparam int FUNC_W   = 2;
   localparam int PRIO_W   = 6;
   localparam int SLOT_F_W = 6;
   localparam int TSTATE_W = 3;
   localparam int STATUS_W = 3;
   localparam int ID_W     = 14;

   // Parameter defaults
   localparam int DEF_TASK_SLOTS          = 64;
   localparam int DEF_PRIORITY_LEVELS     = 32;
   localparam int DEF_GENERATION_BITS     = 8;
   localparam int DEF_ID_GENERATION_SHIFT = 6;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [TSTATE_W-1:0] tstate_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request functions
   localparam func_type FUNC_CREATE   = 2'd0;
   localparam func_type FUNC_SCHEDULE = 2'd1;
   localparam func_type FUNC_REPORT   = 2'd2;

   // Reported task states
   localparam tstate_type TSTATE_READY     = 3'd0;
   localparam tstate_type TSTATE_DESTROYED = 3'd6;
   localparam tstate_type TSTATE_INVALID   = 3'd7;

   // Response status codes
   localparam status_type STATUS_OK         = 3'd0;
   localparam status_type STATUS_BAD_PRIO   = 3'd1;
   localparam status_type STATUS_EXHAUSTED  = 3'd2;
   localparam status_type STATUS_NONE_READY = 3'd3;
   localparam status_type STATUS_BAD_STATE  = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/prqs_channels.sv -----
// Valid/ready channel interfaces for scheduler requests and responses.
`default_nettype none

interface prqs_req_if;
   import prqs_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [PRIO_W-1:0]   priority_req;
   logic [SLOT_F_W-1:0] task_slot;
   logic [TSTATE_W-1:0] new_state;

   modport source (output valid, func, priority_req, task_slot, new_state, input ready);
   modport sink   (input valid, func, priority_req, task_slot, new_state, output ready);
endinterface

interface prqs_rsp_if;
   import prqs_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     task_id;

   modport source (output valid, status, task_id, input ready);
   modport sink   (input valid, status, task_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/priority_ready_queue_scheduler.sv -----
// Task scheduler: per-level FIFO ready queues and a LIFO free list in one link store.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    func, priority_req, task_slot, new_state
//   rsp_ch    out   valid/ready    status, task_id
//
// One request is worked at a time by a small sequencer around the link store, whose
// reads are registered. An error, a schedule with no ready task and any other
// request go from decode straight to the response. The dependent reads set the steps
// of the others: free head, then its link and generation; level choice, then its
// head, then the successor; slot priority, then the level tail.
// req_ch.ready rises in the same cycle that the response is loaded.
// Reset is synchronous: free list starts at slot 0, all levels empty, links and
// generations read as their reset values until first written (per-entry valid bits).
// A waiting response is held in the output register; the next request is taken
// meanwhile and stalls only when its own response is due.
`default_nettype none

module priority_ready_queue_scheduler #(
   parameter int TASK_SLOTS          = prqs_pkg::DEF_TASK_SLOTS,
   parameter int PRIORITY_LEVELS     = prqs_pkg::DEF_PRIORITY_LEVELS,
   parameter int GENERATION_BITS     = prqs_pkg::DEF_GENERATION_BITS,
   parameter int ID_GENERATION_SHIFT = prqs_pkg::DEF_ID_GENERATION_SHIFT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   prqs_req_if.sink   req_ch,
   prqs_rsp_if.source rsp_ch
);
   import prqs_pkg::*;

   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int LINK_W     = $clog2(TASK_SLOTS + 1);
   localparam int LVL_W      = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int SLOT_DEPTH = 1 << SLOT_W;
   localparam int LVL_DEPTH  = 1 << LVL_W;
   localparam int GEN_W      = GENERATION_BITS;
   localparam int ID_WIDE    = GEN_W + ID_GENERATION_SHIFT + SLOT_W;

   localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(TASK_SLOTS);
   localparam logic [8:0]        SLOT_LIMIT = 9'(TASK_SLOTS);
   localparam logic [6:0]        PRIO_LIMIT = 7'(PRIORITY_LEVELS);

   // Sequencer states
   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DECODE    = 9'b000000010,
      S_PRIO_WAIT = 9'b000000100,
      S_LINK      = 9'b000001000,
      S_TERM      = 9'b000010000,
      S_HEAD_RD   = 9'b000100000,
      S_HEAD_DATA = 9'b001000000,
      S_POP       = 9'b010000000,
      S_RESP      = 9'b100000000
   } seq_state_type;

   // Build a task id: slot in the low bits, generation shifted up, cut to id width.
   function automatic logic [ID_W-1:0] make_id(input logic [SLOT_W-1:0] slot,
                                               input logic [GEN_W-1:0]  gen);
      logic [ID_WIDE-1:0] wide;
      wide = (ID_WIDE'(gen) << ID_GENERATION_SHIFT) | ID_WIDE'(slot);
      return ID_W'(wide);
   endfunction

   // Control and captured request
   seq_state_type       state_ff, state_in;
   func_type            op_ff, op_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic [SLOT_F_W-1:0] slot_ff, slot_in;
   tstate_type          nst_ff, nst_in;
   logic [SLOT_W-1:0]   work_slot_ff, work_slot_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   status_type          status_ff, status_in;
   logic [ID_W-1:0]     id_ff, id_in;

   // Scheduler state held in flops
   logic [LINK_W-1:0]     free_head_ff, free_head_in;
   logic [LVL_DEPTH-1:0]  nonempty_ff, nonempty_in;
   logic [SLOT_DEPTH-1:0] nl_valid_ff, nl_valid_in;
   logic [SLOT_DEPTH-1:0] gen_valid_ff, gen_valid_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;

   // Memories: next link, generation, priority per slot; head and tail per level
   logic [LINK_W-1:0] nl_mem   [SLOT_DEPTH];
   logic [GEN_W-1:0]  gen_mem  [SLOT_DEPTH];
   logic [LVL_W-1:0]  prio_mem [SLOT_DEPTH];
   logic [SLOT_W-1:0] head_mem [LVL_DEPTH];
   logic [SLOT_W-1:0] tail_mem [LVL_DEPTH];

   logic              nl_we;
   logic [SLOT_W-1:0] nl_waddr;
   logic [LINK_W-1:0] nl_wdata;
   logic [SLOT_W-1:0] slot_raddr;
   logic [LINK_W-1:0] nl_rdata_ff;
   logic              nl_rvalid_ff;
   logic [SLOT_W-1:0] slot_raddr_ff;

   logic              gen_we;
   logic [GEN_W-1:0]  gen_wdata;
   logic [GEN_W-1:0]  gen_rdata_ff;
   logic              gen_rvalid_ff;

   logic              prio_we;
   logic [LVL_W-1:0]  prio_rdata_ff;

   logic              head_we;
   logic [LVL_W-1:0]  head_waddr;
   logic [SLOT_W-1:0] head_wdata;
   logic [SLOT_W-1:0] head_rdata_ff;

   logic              tail_we;
   logic [LVL_W-1:0]  tail_raddr;
   logic [SLOT_W-1:0] tail_rdata_ff;

   // Values read back, with never-written entries showing their reset values
   logic [LINK_W-1:0] nl_val;
   logic [GEN_W-1:0]  gen_val;

   // Lowest nonempty level
   logic              find_hit;
   logic [LVL_W-1:0]  find_lvl;

   logic [SLOT_W-1:0] free_slot;
   logic [SLOT_W-1:0] req_slot;
   logic [LVL_W-1:0]  req_lvl;

   assign free_slot = free_head_ff[SLOT_W-1:0];
   assign req_slot  = SLOT_W'(slot_ff);
   assign req_lvl   = LVL_W'(prio_ff);
   assign nl_val    = nl_rvalid_ff ? nl_rdata_ff : (LINK_W'(slot_raddr_ff) + LINK_W'(1));
   assign gen_val   = gen_rvalid_ff ? gen_rdata_ff : '0;

   // Handshake ports
   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.task_id = rsp_id_ff;

   // Priority encode the nonempty flags; the lowest level wins.
   always_comb begin
      find_hit = 1'b0;
      find_lvl = '0;
      for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            find_hit = 1'b1;
            find_lvl = LVL_W'(i);
         end
      end
   end

   // Memory ports, read data registered
   always_ff @(posedge clock) begin
      if (nl_we) begin
         nl_mem[nl_waddr] <= nl_wdata;
      end
      nl_rdata_ff   <= nl_mem[slot_raddr];
      nl_rvalid_ff  <= nl_valid_ff[slot_raddr];
      slot_raddr_ff <= slot_raddr;
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[work_slot_ff] <= gen_wdata;
      end
      gen_rdata_ff  <= gen_mem[slot_raddr];
      gen_rvalid_ff <= gen_valid_ff[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (prio_we) begin
         prio_mem[work_slot_ff] <= lvl_ff;
      end
      prio_rdata_ff <= prio_mem[req_slot];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rdata_ff <= head_mem[lvl_ff];
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[lvl_ff] <= work_slot_ff;
      end
      tail_rdata_ff <= tail_mem[tail_raddr];
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      prio_in       = prio_ff;
      slot_in       = slot_ff;
      nst_in        = nst_ff;
      work_slot_in  = work_slot_ff;
      lvl_in        = lvl_ff;
      status_in     = status_ff;
      id_in         = id_ff;
      free_head_in  = free_head_ff;
      nonempty_in   = nonempty_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;

      nl_we      = 1'b0;
      nl_waddr   = work_slot_ff;
      nl_wdata   = NULL_LINK;
      gen_we     = 1'b0;
      gen_wdata  = gen_val + GEN_W'(1);
      prio_we    = 1'b0;
      head_we    = 1'b0;
      head_waddr = lvl_ff;
      head_wdata = work_slot_ff;
      tail_we    = 1'b0;
      slot_raddr = free_slot;
      tail_raddr = req_lvl;

      // Drop the response once taken.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.func;
               prio_in  = req_ch.priority_req;
               slot_in  = req_ch.task_slot;
               nst_in   = req_ch.new_state;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = STATUS_OK;
            id_in     = '0;
            state_in  = S_RESP;
            unique case (op_ff)
               FUNC_CREATE: begin
                  // Link and generation reads for the free head and the tail read for the level go out now.
                  if (7'(prio_ff) >= PRIO_LIMIT) begin
                     status_in = STATUS_BAD_PRIO;
                  end else if (free_head_ff >= NULL_LINK) begin
                     status_in = STATUS_EXHAUSTED;
                  end else begin
                     work_slot_in = free_slot;
                     lvl_in       = req_lvl;
                     state_in     = S_LINK;
                  end
               end
               FUNC_SCHEDULE: begin
                  lvl_in = find_lvl;
                  if (find_hit) begin
                     state_in = S_HEAD_RD;
                  end else begin
                     status_in = STATUS_NONE_READY;
                  end
               end
               FUNC_REPORT: begin
                  if (nst_ff == TSTATE_INVALID) begin
                     status_in = STATUS_BAD_STATE;
                  end else if (9'(slot_ff) < SLOT_LIMIT) begin
                     if (nst_ff == TSTATE_READY) begin
                        // Priority read of the slot goes out now.
                        work_slot_in = req_slot;
                        state_in     = S_PRIO_WAIT;
                     end else if (nst_ff == TSTATE_DESTROYED) begin
                        // Push the slot onto the free list.
                        nl_we        = 1'b1;
                        nl_waddr     = req_slot;
                        nl_wdata     = free_head_ff;
                        free_head_in = LINK_W'(req_slot);
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         S_PRIO_WAIT: begin
            tail_raddr = prio_rdata_ff;
            lvl_in     = prio_rdata_ff;
            if (7'(prio_rdata_ff) >= PRIO_LIMIT) begin
               state_in = S_RESP;
            end else begin
               state_in = S_LINK;
            end
         end

         S_LINK: begin
            // Append to the level: chain behind the tail, or start the queue.
            if (nonempty_ff[lvl_ff]) begin
               nl_we    = 1'b1;
               nl_waddr = tail_rdata_ff;
               nl_wdata = LINK_W'(work_slot_ff);
            end else begin
               head_we             = 1'b1;
               nonempty_in[lvl_ff] = 1'b1;
            end
            if (op_ff == FUNC_CREATE) begin
               // Pop the free list and advance the slot's generation.
               free_head_in = nl_val;
               gen_we       = 1'b1;
               prio_we      = 1'b1;
               id_in        = make_id(work_slot_ff, gen_val);
            end
            state_in = S_TERM;
         end

         S_TERM: begin
            nl_we    = 1'b1;
            tail_we  = 1'b1;
            state_in = S_RESP;
         end

         S_HEAD_RD: begin
            state_in = S_HEAD_DATA;
         end

         S_HEAD_DATA: begin
            slot_raddr   = head_rdata_ff;
            work_slot_in = head_rdata_ff;
            state_in     = S_POP;
         end

         S_POP: begin
            // Unlink the head; an empty successor empties the level.
            nl_we = 1'b1;
            if (nl_val >= NULL_LINK) begin
               nonempty_in[lvl_ff] = 1'b0;
            end else begin
               head_we    = 1'b1;
               head_wdata = nl_val[SLOT_W-1:0];
            end
            id_in    = make_id(work_slot_ff, gen_val - GEN_W'(1));
            state_in = S_RESP;
         end

         S_RESP: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = id_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      nl_valid_in  = nl_valid_ff;
      gen_valid_in = gen_valid_ff;
      if (nl_we) begin
         nl_valid_in[nl_waddr] = 1'b1;
      end
      if (gen_we) begin
         gen_valid_in[work_slot_ff] = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         nonempty_ff  <= '0;
         nl_valid_ff  <= '0;
         gen_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         nonempty_ff  <= nonempty_in;
         nl_valid_ff  <= nl_valid_in;
         gen_valid_ff <= gen_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      prio_ff       <= prio_in;
      slot_ff       <= slot_in;
      nst_ff        <= nst_in;
      work_slot_ff  <= work_slot_in;
      lvl_ff        <= lvl_in;
      status_ff     <= status_in;
      id_ff         <= id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

endmodule

`default_nettype wire
